/* design/mtbc_pkg.sv */
// Package for the markup tag balance checker.
// Holds sizes, derived widths, character codes, parse modes and result causes.
// Has no dependencies.
package mtbc_pkg;

  // Sizing
  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned NAME_BYTES  = 32;
  localparam int unsigned TAG_CAPTURE = 255;

  // Derived widths
  localparam int unsigned TOP_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ROW_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned COL_W   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int unsigned IDX_W   = $clog2(NAME_BYTES + 2);
  localparam int unsigned LEN_W   = $clog2(NAME_BYTES + 1);
  localparam int unsigned CNT_W   = $clog2(TAG_CAPTURE + 1);
  localparam int unsigned NAME_AW = ROW_W + COL_W;
  localparam int unsigned NAME_DEPTH = 1 << NAME_AW;

  // Character codes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_START,
    MODE_OPEN_NAME,
    MODE_OPEN_REST,
    MODE_CLOSE_NAME,
    MODE_CLOSE_REST
  } mode_e;

  typedef enum logic [2:0] {
    CAUSE_OK,
    CAUSE_MISMATCH,
    CAUSE_EMPTY_CLOSE,
    CAUSE_UNCLOSED,
    CAUSE_TOO_LONG
  } cause_e;

  // Name delimiter: whitespace or slash
  function automatic logic is_delim(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_SLASH};
  endfunction

endpackage

/* design/mtbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the name byte and name length stores.
module mtbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/markup_tag_balance_checker.sv */
// Markup tag balance checker, top level.
// Depends on mtbc_pkg and mtbc_ram.
//
// Takes a document one byte per item and checks that its tags nest and close
// properly. A '<' starts a tag; it ends at '>' or once TAG_CAPTURE bytes have
// been captured, in which case the following byte is dropped. Opening tags
// push their name (up to whitespace or '/') onto a name stack held in RAM;
// closing tags pop it and compare names byte by byte. On the item flagged as
// last byte, any open tag is finished, one result item gives the verdict and
// cause (first failure wins; a non-empty stack reports unclosed tags), and the
// block returns to its reset state. Rate: one byte accepted every cycle
// while in_stall_o is low; a result is registered into the output buffer.
// The single read port of the name byte RAM sets that rate: the byte a
// closing name is compared against is prefetched from the next state's
// stack top and name position, so each byte finds its data waiting. Same-
// address write/read collisions are forwarded. A two-deep output buffer lets
// input keep flowing while a result waits; input stalls only when both
// result slots are full. No clearing pass after reset: name stores are only
// read where an earlier push wrote them.
module markup_tag_balance_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       balanced_o,
  output logic [2:0] cause_o
);

  // Parse state
  mtbc_pkg::mode_e                   mode_q, mode_d;
  logic [mtbc_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [mtbc_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic [mtbc_pkg::TOP_W-1:0]        top_q, top_d;
  logic                              match_q, match_d;
  mtbc_pkg::cause_e                  fail_q, fail_d;
  logic                              skip_q, skip_d;

  // Output buffer (main slot plus skid slot)
  logic                              out_valid_q, out_valid_d;
  logic                              out_bal_q, out_bal_d;
  mtbc_pkg::cause_e                  out_cause_q, out_cause_d;
  logic                              skid_valid_q, skid_valid_d;
  logic                              skid_bal_q, skid_bal_d;
  mtbc_pkg::cause_e                  skid_cause_q, skid_cause_d;

  // Memory ports
  logic                              name_we;
  logic [mtbc_pkg::NAME_AW-1:0]      name_waddr, name_raddr;
  logic [7:0]                        name_rdata, name_rd;
  logic                              len_we;
  logic [mtbc_pkg::ROW_W-1:0]        len_waddr, len_raddr;
  logic [mtbc_pkg::LEN_W-1:0]        len_rdata, len_rd;

  // Forwarding of same-cycle write to the prefetched address
  logic                              name_fwd_q, name_fwd_d;
  logic [7:0]                        name_fwd_data_q;
  logic                              len_fwd_q, len_fwd_d;
  logic [mtbc_pkg::LEN_W-1:0]        len_fwd_data_q;

  logic                              accept;
  logic                              res_valid;
  logic                              res_bal;
  mtbc_pkg::cause_e                  res_cause;
  logic [mtbc_pkg::TOP_W-1:0]        top_dec;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = skid_valid_q;

  assign name_rd = name_fwd_q ? name_fwd_data_q : name_rdata;
  assign len_rd  = len_fwd_q ? len_fwd_data_q : len_rdata;

  // Parse next state and stack datapath
  always_comb begin
    logic finish;
    logic close_ok;
    mtbc_pkg::mode_e m1;
    m1        = mode_q;
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    top_d     = top_q;
    match_d   = match_q;
    fail_d    = fail_q;
    skip_d    = skip_q;
    name_we   = 1'b0;
    len_we    = 1'b0;
    finish    = 1'b0;
    close_ok  = 1'b0;
    res_valid = 1'b0;
    res_bal   = 1'b0;
    res_cause = mtbc_pkg::CAUSE_OK;

    if (accept && skip_q) begin
      skip_d = 1'b0;
    end else if (accept && fail_q == mtbc_pkg::CAUSE_OK) begin
      if (mode_q == mtbc_pkg::MODE_TEXT) begin
        if (char_byte_i == mtbc_pkg::CH_LT) begin
          mode_d  = mtbc_pkg::MODE_START;
          cnt_d   = '0;
          idx_d   = '0;
          match_d = 1'b1;
        end
      end else if (char_byte_i == mtbc_pkg::CH_GT) begin
        finish = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        case (mode_q)
          mtbc_pkg::MODE_START, mtbc_pkg::MODE_OPEN_NAME: begin
            if (mode_q == mtbc_pkg::MODE_START && char_byte_i == mtbc_pkg::CH_SLASH) begin
              mode_d = mtbc_pkg::MODE_CLOSE_NAME;
            end else if (mtbc_pkg::is_delim(char_byte_i)) begin
              mode_d = mtbc_pkg::MODE_OPEN_REST;
            end else begin
              mode_d = mtbc_pkg::MODE_OPEN_NAME;
              if (idx_q >= mtbc_pkg::IDX_W'(mtbc_pkg::NAME_BYTES)) begin
                fail_d = mtbc_pkg::CAUSE_TOO_LONG;
              end else begin
                name_we = (top_q < mtbc_pkg::TOP_W'(mtbc_pkg::STACK_DEPTH));
                idx_d   = idx_q + 1'b1;
              end
            end
          end
          mtbc_pkg::MODE_CLOSE_NAME: begin
            if (mtbc_pkg::is_delim(char_byte_i)) begin
              mode_d = mtbc_pkg::MODE_CLOSE_REST;
            end else begin
              // compare against the prefetched byte of the top name
              if (top_q != '0 &&
                  !(idx_q < mtbc_pkg::IDX_W'(len_rd) &&
                    idx_q < mtbc_pkg::IDX_W'(mtbc_pkg::NAME_BYTES) &&
                    name_rd == char_byte_i)) begin
                match_d = 1'b0;
              end
              if (idx_q <= mtbc_pkg::IDX_W'(mtbc_pkg::NAME_BYTES)) begin
                idx_d = idx_q + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (fail_d == mtbc_pkg::CAUSE_OK &&
            cnt_d >= mtbc_pkg::CNT_W'(mtbc_pkg::TAG_CAPTURE)) begin
          finish = 1'b1;
          skip_d = 1'b1;
        end
      end
    end

    // Last byte closes any tag still open
    if (accept && last_byte_i && fail_d == mtbc_pkg::CAUSE_OK &&
        mode_d != mtbc_pkg::MODE_TEXT) begin
      finish = 1'b1;
    end

    if (finish) begin
      m1 = mode_d;
      case (m1)
        mtbc_pkg::MODE_OPEN_NAME, mtbc_pkg::MODE_OPEN_REST: begin
          if (top_q < mtbc_pkg::TOP_W'(mtbc_pkg::STACK_DEPTH)) begin
            len_we = 1'b1;
            top_d  = top_q + 1'b1;
          end
        end
        mtbc_pkg::MODE_CLOSE_NAME, mtbc_pkg::MODE_CLOSE_REST: begin
          close_ok = match_d && (idx_d == mtbc_pkg::IDX_W'(len_rd));
          if (top_q == '0) begin
            if (fail_d == mtbc_pkg::CAUSE_OK) begin
              fail_d = mtbc_pkg::CAUSE_EMPTY_CLOSE;
            end
          end else begin
            if (!close_ok && fail_d == mtbc_pkg::CAUSE_OK) begin
              fail_d = mtbc_pkg::CAUSE_MISMATCH;
            end
            top_d = top_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
      mode_d  = mtbc_pkg::MODE_TEXT;
      cnt_d   = '0;
      idx_d   = '0;
      match_d = 1'b1;
    end

    // Verdict, then back to reset state
    if (accept && last_byte_i) begin
      res_valid = 1'b1;
      if (fail_d != mtbc_pkg::CAUSE_OK) begin
        res_cause = fail_d;
      end else if (top_d != '0) begin
        res_cause = mtbc_pkg::CAUSE_UNCLOSED;
      end else begin
        res_cause = mtbc_pkg::CAUSE_OK;
      end
      res_bal = (res_cause == mtbc_pkg::CAUSE_OK);
      mode_d  = mtbc_pkg::MODE_TEXT;
      cnt_d   = '0;
      idx_d   = '0;
      top_d   = '0;
      match_d = 1'b1;
      fail_d  = mtbc_pkg::CAUSE_OK;
      skip_d  = 1'b0;
    end
  end

  // Memory addressing: write at the current stack slot, prefetch the next top
  assign name_waddr = {top_q[mtbc_pkg::ROW_W-1:0], idx_q[mtbc_pkg::COL_W-1:0]};
  assign len_waddr  = top_q[mtbc_pkg::ROW_W-1:0];
  assign top_dec    = top_d - 1'b1;
  assign len_raddr  = top_dec[mtbc_pkg::ROW_W-1:0];
  assign name_raddr = {top_dec[mtbc_pkg::ROW_W-1:0], idx_d[mtbc_pkg::COL_W-1:0]};

  // Length to store is taken before idx_d clears on finish
  logic [mtbc_pkg::LEN_W-1:0] len_wdata_pre;
  logic [mtbc_pkg::IDX_W-1:0] idx_pre;
  assign idx_pre       = (name_we) ? idx_q + 1'b1 : idx_q;
  assign len_wdata_pre = idx_pre[mtbc_pkg::LEN_W-1:0];

  assign name_fwd_d = name_we && (name_waddr == name_raddr);
  assign len_fwd_d  = len_we && (len_waddr == len_raddr);

  // Output buffer
  always_comb begin
    out_valid_d  = out_valid_q;
    out_bal_d    = out_bal_q;
    out_cause_d  = out_cause_q;
    skid_valid_d = skid_valid_q;
    skid_bal_d   = skid_bal_q;
    skid_cause_d = skid_cause_q;
    if (out_valid_q && !out_stall_i) begin
      if (skid_valid_q) begin
        out_bal_d    = skid_bal_q;
        out_cause_d  = skid_cause_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_bal_d   = res_bal;
        out_cause_d = res_cause;
      end else begin
        skid_valid_d = 1'b1;
        skid_bal_d   = res_bal;
        skid_cause_d = res_cause;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign balanced_o  = out_bal_q;
  assign cause_o     = out_cause_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mtbc_pkg::MODE_TEXT;
      cnt_q        <= '0;
      idx_q        <= '0;
      top_q        <= '0;
      match_q      <= 1'b1;
      fail_q       <= mtbc_pkg::CAUSE_OK;
      skip_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      name_fwd_q   <= 1'b0;
      len_fwd_q    <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      top_q        <= top_d;
      match_q      <= match_d;
      fail_q       <= fail_d;
      skip_q       <= skip_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      name_fwd_q   <= name_fwd_d;
      len_fwd_q    <= len_fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bal_q       <= out_bal_d;
    out_cause_q     <= out_cause_d;
    skid_bal_q      <= skid_bal_d;
    skid_cause_q    <= skid_cause_d;
    name_fwd_data_q <= char_byte_i;
    len_fwd_data_q  <= len_wdata_pre;
  end

  mtbc_ram #(
    .WIDTH (8),
    .DEPTH (mtbc_pkg::NAME_DEPTH)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_waddr),
    .wdata_i (char_byte_i),
    .raddr_i (name_raddr),
    .rdata_o (name_rdata)
  );

  // Lengths written from the pre-finish name position
  mtbc_ram #(
    .WIDTH (mtbc_pkg::LEN_W),
    .DEPTH (mtbc_pkg::STACK_DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata_pre),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // Assertions
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while main output slot empty");

  a_top_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= mtbc_pkg::TOP_W'(mtbc_pkg::STACK_DEPTH))
    else $error("stack top beyond depth");

  a_verdict_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (balanced_o == (cause_o == 3'(mtbc_pkg::CAUSE_OK))))
    else $error("balanced flag disagrees with cause");

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_byte_i) |=> (top_q == '0 && mode_q == mtbc_pkg::MODE_TEXT &&
                                 fail_q == mtbc_pkg::CAUSE_OK))
    else $error("state not cleared after last byte");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= mtbc_pkg::IDX_W'(mtbc_pkg::NAME_BYTES + 1))
    else $error("name index out of range");

endmodule
